[src/i2cseq_pkg.sv]
`timescale 1ns / 1ps
// Shared types, codes and sizes for the I2C master transaction sequencer.
// No dependencies; every other file in src imports this package.
package i2cseq_pkg;

  localparam int BYTE_W        = 8;
  localparam int CNT_W         = 8;
  localparam int KIND_W        = 2;
  localparam int CMD_W         = 3;
  localparam int STEP_W        = 3;
  localparam int MAX_BYTES_DEF = 128;
  localparam int FQ_DEPTH      = 4;
  localparam int OQ_DEPTH      = 4;

  // Input item kinds
  localparam logic [KIND_W-1:0] KIND_BEGIN = 2'd0;
  localparam logic [KIND_W-1:0] KIND_LOAD  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_EVENT = 2'd2;
  localparam logic [KIND_W-1:0] KIND_ERROR = 2'd3;

  // Bus commands on the result channel
  localparam logic [CMD_W-1:0] CMD_START = 3'd0;
  localparam logic [CMD_W-1:0] CMD_ADDR  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_DATA  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_ACK   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_NACK  = 3'd4;
  localparam logic [CMD_W-1:0] CMD_STOP  = 3'd5;
  localparam logic [CMD_W-1:0] CMD_READ  = 3'd6;
  localparam logic [CMD_W-1:0] CMD_DONE  = 3'd7;

  // Work steps run by the back end, in event flag order for the bus steps
  localparam logic [STEP_W-1:0] STEP_BEGIN = 3'd0;
  localparam logic [STEP_W-1:0] STEP_LOAD  = 3'd1;
  localparam logic [STEP_W-1:0] STEP_SB    = 3'd2;
  localparam logic [STEP_W-1:0] STEP_AD    = 3'd3;
  localparam logic [STEP_W-1:0] STEP_RX    = 3'd4;
  localparam logic [STEP_W-1:0] STEP_TE    = 3'd5;
  localparam logic [STEP_W-1:0] STEP_FAIL  = 3'd6;
  localparam logic [STEP_W-1:0] STEP_ERR   = 3'd7;

  // Classified item as queued between front and back
  typedef struct packed {
    logic [STEP_W-1:0] first_step;
    logic              counts_bad;
    logic [BYTE_W-1:0] device_address;
    logic [CNT_W-1:0]  write_count;
    logic [CNT_W-1:0]  read_count;
    logic [BYTE_W-1:0] tx_byte;
    logic              flag_start_sent;
    logic              flag_address_done;
    logic              flag_rx_ready;
    logic              flag_tx_empty;
    logic [BYTE_W-1:0] rx_byte;
  } item_t;

  // One result item
  typedef struct packed {
    logic [CMD_W-1:0]  command;
    logic [BYTE_W-1:0] data_byte;
    logic              status;
    logic              last;
  } res_t;

endpackage

[src/i2cseq_front.sv]
`timescale 1ns / 1ps
// Front end: accepts input items, classifies them and queues them for the back end.
// Depends on i2cseq_pkg.
module i2cseq_front import i2cseq_pkg::*; #(
  parameter int MAX_BYTES = MAX_BYTES_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_push,
  output logic              in_full,
  input  logic [KIND_W-1:0] in_kind,
  input  logic [BYTE_W-1:0] in_device_address,
  input  logic [CNT_W-1:0]  in_write_count,
  input  logic [CNT_W-1:0]  in_read_count,
  input  logic [BYTE_W-1:0] in_tx_byte,
  input  logic              in_flag_start_sent,
  input  logic              in_flag_address_done,
  input  logic              in_flag_rx_ready,
  input  logic              in_flag_tx_empty,
  input  logic [BYTE_W-1:0] in_rx_byte,
  output item_t             q_item,
  output logic              q_valid,
  input  logic              q_take
);

  localparam int FQ_AW = (FQ_DEPTH > 1) ? $clog2(FQ_DEPTH) : 1;
  localparam logic [CNT_W:0]   MAX_CNT  = (CNT_W + 1)'(MAX_BYTES);
  localparam logic [FQ_AW-1:0] PTR_LAST = FQ_AW'(FQ_DEPTH - 1);
  localparam logic [FQ_AW:0]   CNT_FULL = (FQ_AW + 1)'(FQ_DEPTH);

  item_t             cls;
  item_t             fifo_r [FQ_DEPTH];
  logic [FQ_AW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [FQ_AW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [FQ_AW:0]    cnt_r, cnt_nxt;
  logic              push_ok;
  logic              pop_ok;

  // Classify: pick the first work step and check the begin counts
  always_comb begin
    cls.device_address    = in_device_address;
    cls.write_count       = in_write_count;
    cls.read_count        = in_read_count;
    cls.tx_byte           = in_tx_byte;
    cls.flag_start_sent   = in_flag_start_sent;
    cls.flag_address_done = in_flag_address_done;
    cls.flag_rx_ready     = in_flag_rx_ready;
    cls.flag_tx_empty     = in_flag_tx_empty;
    cls.rx_byte           = in_rx_byte;
    cls.counts_bad        = ({1'b0, in_write_count} > MAX_CNT) ||
                            ({1'b0, in_read_count} > MAX_CNT);
    unique case (in_kind)
      KIND_BEGIN: cls.first_step = STEP_BEGIN;
      KIND_LOAD:  cls.first_step = STEP_LOAD;
      KIND_ERROR: cls.first_step = STEP_ERR;
      KIND_EVENT: begin
        if (in_flag_start_sent)        cls.first_step = STEP_SB;
        else if (in_flag_address_done) cls.first_step = STEP_AD;
        else if (in_flag_rx_ready)     cls.first_step = STEP_RX;
        else if (in_flag_tx_empty)     cls.first_step = STEP_TE;
        else                           cls.first_step = STEP_FAIL;
      end
      default: cls.first_step = STEP_FAIL;
    endcase
  end

  // Queue handshake
  assign in_full = (cnt_r == CNT_FULL);
  assign q_valid = (cnt_r != '0);
  assign q_item  = fifo_r[rd_ptr_r];
  assign push_ok = in_push && !in_full;
  assign pop_ok  = q_take && q_valid;

  // Advance pointers and fill count
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push_ok) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + FQ_AW'(1);
    end
    if (pop_ok) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + FQ_AW'(1);
    end
    if (push_ok && !pop_ok) begin
      cnt_nxt = cnt_r + (FQ_AW + 1)'(1);
    end else if (pop_ok && !push_ok) begin
      cnt_nxt = cnt_r - (FQ_AW + 1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Store the classified item
  always_ff @(posedge clk) begin
    if (push_ok) begin
      fifo_r[wr_ptr_r] <= cls;
    end
  end

endmodule

[src/i2cseq_back.sv]
`timescale 1ns / 1ps
// Back end: transaction state, write store and the step sequencer that emits results.
// Depends on i2cseq_pkg.
module i2cseq_back import i2cseq_pkg::*; #(
  parameter int MAX_BYTES = MAX_BYTES_DEF
) (
  input  logic  clk,
  input  logic  rst_n,
  input  item_t q_item,
  input  logic  q_valid,
  output logic  q_take,
  output res_t  oq_data,
  output logic  oq_push,
  input  logic  oq_full
);

  localparam int PW = $clog2(MAX_BYTES + 1);
  localparam int AW = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1;
  localparam logic [PW-1:0] MAX_PTR = PW'(MAX_BYTES);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_STEP  = 2'd1;
  localparam logic [1:0] ST_FLUSH = 2'd2;

  function automatic res_t mk_res(input logic [CMD_W-1:0] cmd,
                                  input logic [BYTE_W-1:0] data,
                                  input logic st);
    res_t r;
    r.command   = cmd;
    r.data_byte = data;
    r.status    = st;
    r.last      = 1'b0;
    return r;
  endfunction

  // Sequencer registers
  logic [1:0]        st_r, st_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic [1:0]        sub_r, sub_nxt;
  item_t             item_r;
  res_t              hold_r, hold_nxt;
  logic              hold_vld_r, hold_vld_nxt;

  // Transaction state
  logic [PW-1:0]     wp_r, wp_nxt;
  logic [PW-1:0]     rp_r, rp_nxt;
  logic [CNT_W-1:0]  wl_r, wl_nxt;
  logic [CNT_W-1:0]  rl_r, rl_nxt;
  logic [BYTE_W-1:0] tgt_r, tgt_nxt;
  logic              rd_r, rd_nxt;
  logic              failed_r, failed_nxt;

  // Write store
  logic [BYTE_W-1:0] store_r [MAX_BYTES];
  logic [BYTE_W-1:0] rdata_r;

  // Transmit staging outcome
  logic [1:0]        tx_n;
  res_t              tx_r0, tx_r1;
  logic [PW-1:0]     tx_wp, tx_rp;
  logic [CNT_W-1:0]  tx_wl;
  logic              tx_rd, tx_failed;

  // Current step outcome
  logic [1:0]        n;
  res_t              r0, r1, r2, cur;
  logic [PW-1:0]     e_wp, e_rp;
  logic [CNT_W-1:0]  e_wl, e_rl;
  logic [BYTE_W-1:0] e_tgt;
  logic              e_rd, e_failed, e_wr;
  logic              nxt_has;
  logic [STEP_W-1:0] nxt_step;

  logic can_emit, fire, step_end, flush_push, flush_done;

  // Stage the next write byte or fail, or turn around / finish when writes are over
  always_comb begin
    tx_n      = 2'd0;
    tx_r0     = '0;
    tx_r1     = '0;
    tx_wp     = wp_r;
    tx_rp     = rp_r;
    tx_wl     = wl_r;
    tx_rd     = rd_r;
    tx_failed = failed_r;
    if (wl_r != '0 && !failed_r) begin
      if (rp_r >= wp_r || rp_r >= MAX_PTR) begin
        tx_failed = 1'b1;
      end else begin
        tx_n  = 2'd1;
        tx_r0 = mk_res(CMD_DATA, rdata_r, 1'b0);
        tx_rp = rp_r + PW'(1);
        tx_wl = wl_r - CNT_W'(1);
      end
    end else if (rl_r == '0) begin
      tx_n  = 2'd2;
      tx_r0 = mk_res(CMD_STOP, '0, 1'b0);
      tx_r1 = mk_res(CMD_DONE, '0, failed_r);
      tx_wp = '0;
      tx_rp = '0;
    end else begin
      tx_n  = 2'd2;
      tx_rd = 1'b1;
      tx_r0 = mk_res(CMD_ACK, '0, 1'b0);
      tx_r1 = mk_res(CMD_START, '0, 1'b0);
    end
  end

  // Evaluate the current step: results to emit and state at its end
  always_comb begin
    n        = 2'd0;
    r0       = '0;
    r1       = '0;
    r2       = '0;
    e_wp     = wp_r;
    e_rp     = rp_r;
    e_wl     = wl_r;
    e_rl     = rl_r;
    e_tgt    = tgt_r;
    e_rd     = rd_r;
    e_failed = failed_r;
    e_wr     = 1'b0;
    unique case (step_r)
      STEP_BEGIN: begin
        n = 2'd1;
        if (item_r.counts_bad) begin
          r0 = mk_res(CMD_DONE, '0, 1'b1);
        end else begin
          r0       = mk_res(CMD_START, '0, 1'b0);
          e_tgt    = item_r.device_address;
          e_wl     = item_r.write_count;
          e_rl     = item_r.read_count;
          e_rd     = (item_r.write_count == '0);
          e_failed = 1'b0;
          e_rp     = '0;
        end
      end
      STEP_LOAD: begin
        if (wp_r < MAX_PTR) begin
          e_wr = 1'b1;
          e_wp = wp_r + PW'(1);
        end
      end
      STEP_SB: begin
        n  = 2'd1;
        r0 = mk_res(CMD_ADDR, {tgt_r[BYTE_W-1:1], rd_r}, 1'b0);
      end
      STEP_AD: begin
        if (rl_r == CNT_W'(1) && rd_r) begin
          n  = 2'd2;
          r0 = mk_res(CMD_NACK, '0, 1'b0);
          r1 = mk_res(CMD_STOP, '0, 1'b0);
        end else if (!rd_r) begin
          n        = tx_n;
          r0       = tx_r0;
          r1       = tx_r1;
          e_wp     = tx_wp;
          e_rp     = tx_rp;
          e_wl     = tx_wl;
          e_rd     = tx_rd;
          e_failed = tx_failed;
        end
      end
      STEP_RX: begin
        if (rl_r != '0 && !failed_r) begin
          e_rl = rl_r - CNT_W'(1);
          r0   = mk_res(CMD_READ, item_r.rx_byte, 1'b0);
          if (rl_r == CNT_W'(2)) begin
            n  = 2'd3;
            r1 = mk_res(CMD_NACK, '0, 1'b0);
            r2 = mk_res(CMD_STOP, '0, 1'b0);
          end else if (rl_r == CNT_W'(1)) begin
            n    = 2'd2;
            r1   = mk_res(CMD_DONE, '0, failed_r);
            e_wp = '0;
            e_rp = '0;
          end else begin
            n = 2'd1;
          end
        end else begin
          n    = 2'd1;
          r0   = mk_res(CMD_DONE, '0, failed_r);
          e_wp = '0;
          e_rp = '0;
        end
      end
      STEP_TE: begin
        n        = tx_n;
        r0       = tx_r0;
        r1       = tx_r1;
        e_wp     = tx_wp;
        e_rp     = tx_rp;
        e_wl     = tx_wl;
        e_rd     = tx_rd;
        e_failed = tx_failed;
      end
      STEP_FAIL: begin
        if (failed_r) begin
          n  = 2'd1;
          r0 = mk_res(CMD_STOP, '0, 1'b0);
        end
      end
      STEP_ERR: begin
        n        = 2'd2;
        r0       = mk_res(CMD_STOP, '0, 1'b0);
        r1       = mk_res(CMD_DONE, '0, 1'b1);
        e_failed = 1'b1;
        e_wp     = '0;
        e_rp     = '0;
      end
      default: begin
        n = 2'd0;
      end
    endcase
  end

  // Pick the step after this one from the remaining event flags
  always_comb begin
    nxt_has  = 1'b1;
    nxt_step = STEP_FAIL;
    unique case (step_r)
      STEP_SB: begin
        if (item_r.flag_address_done)  nxt_step = STEP_AD;
        else if (item_r.flag_rx_ready) nxt_step = STEP_RX;
        else if (item_r.flag_tx_empty) nxt_step = STEP_TE;
      end
      STEP_AD: begin
        if (item_r.flag_rx_ready)      nxt_step = STEP_RX;
        else if (item_r.flag_tx_empty) nxt_step = STEP_TE;
      end
      STEP_RX: begin
        if (item_r.flag_tx_empty) nxt_step = STEP_TE;
      end
      STEP_TE: nxt_step = STEP_FAIL;
      default: nxt_has = 1'b0;
    endcase
  end

  // Select the result for this sub-step
  always_comb begin
    case (sub_r)
      2'd0:    cur = r0;
      2'd1:    cur = r1;
      default: cur = r2;
    endcase
  end

  // Emit through the hold register so the final result of an item can be marked
  assign can_emit   = !hold_vld_r || !oq_full;
  assign fire       = (st_r == ST_STEP) && (sub_r < n) && can_emit;
  assign step_end   = (st_r == ST_STEP) &&
                      ((n == 2'd0) || (fire && (sub_r == n - 2'd1)));
  assign flush_push = (st_r == ST_FLUSH) && hold_vld_r && !oq_full;
  assign flush_done = (st_r == ST_FLUSH) && (!hold_vld_r || !oq_full);
  assign q_take     = q_valid && ((st_r == ST_IDLE) || flush_done);
  assign oq_push    = (fire && hold_vld_r) || flush_push;

  always_comb begin
    oq_data      = hold_r;
    oq_data.last = (st_r == ST_FLUSH);
  end

  always_comb begin
    hold_nxt     = hold_r;
    hold_vld_nxt = hold_vld_r;
    if (fire) begin
      hold_nxt     = cur;
      hold_vld_nxt = 1'b1;
    end else if (flush_push) begin
      hold_vld_nxt = 1'b0;
    end
  end

  // Sequencer control
  always_comb begin
    st_nxt   = st_r;
    step_nxt = step_r;
    sub_nxt  = sub_r;
    unique case (st_r)
      ST_IDLE: begin
        if (q_take) begin
          st_nxt   = ST_STEP;
          step_nxt = q_item.first_step;
          sub_nxt  = 2'd0;
        end
      end
      ST_STEP: begin
        if (step_end) begin
          sub_nxt = 2'd0;
          if (nxt_has) begin
            step_nxt = nxt_step;
          end else begin
            st_nxt = ST_FLUSH;
          end
        end else if (fire) begin
          sub_nxt = sub_r + 2'd1;
        end
      end
      ST_FLUSH: begin
        if (flush_done) begin
          if (q_take) begin
            st_nxt   = ST_STEP;
            step_nxt = q_item.first_step;
            sub_nxt  = 2'd0;
          end else begin
            st_nxt = ST_IDLE;
          end
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  // Commit transaction state at the end of a step
  always_comb begin
    wp_nxt     = wp_r;
    rp_nxt     = rp_r;
    wl_nxt     = wl_r;
    rl_nxt     = rl_r;
    tgt_nxt    = tgt_r;
    rd_nxt     = rd_r;
    failed_nxt = failed_r;
    if (step_end) begin
      wp_nxt     = e_wp;
      rp_nxt     = e_rp;
      wl_nxt     = e_wl;
      rl_nxt     = e_rl;
      tgt_nxt    = e_tgt;
      rd_nxt     = e_rd;
      failed_nxt = e_failed;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r       <= ST_IDLE;
      step_r     <= STEP_FAIL;
      sub_r      <= 2'd0;
      hold_vld_r <= 1'b0;
      wp_r       <= '0;
      rp_r       <= '0;
      wl_r       <= '0;
      rl_r       <= '0;
      tgt_r      <= '0;
      rd_r       <= 1'b0;
      failed_r   <= 1'b0;
    end else begin
      st_r       <= st_nxt;
      step_r     <= step_nxt;
      sub_r      <= sub_nxt;
      hold_vld_r <= hold_vld_nxt;
      wp_r       <= wp_nxt;
      rp_r       <= rp_nxt;
      wl_r       <= wl_nxt;
      rl_r       <= rl_nxt;
      tgt_r      <= tgt_nxt;
      rd_r       <= rd_nxt;
      failed_r   <= failed_nxt;
    end
  end

  // Hold payload: item under work and the pending result
  always_ff @(posedge clk) begin
    if (q_take) begin
      item_r <= q_item;
    end
    hold_r <= hold_nxt;
  end

  // Write store: one write port, registered read at the next read pointer
  always_ff @(posedge clk) begin
    if (step_end && e_wr) begin
      store_r[wp_r[AW-1:0]] <= item_r.tx_byte;
    end
    rdata_r <= store_r[rp_nxt[AW-1:0]];
  end

endmodule

[src/i2cseq_outq.sv]
`timescale 1ns / 1ps
// Result queue between the back end and the result ports.
// Depends on i2cseq_pkg.
module i2cseq_outq import i2cseq_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  res_t din,
  output logic full,
  output logic empty,
  input  logic pop,
  output res_t dout
);

  localparam int OQ_AW = (OQ_DEPTH > 1) ? $clog2(OQ_DEPTH) : 1;
  localparam logic [OQ_AW-1:0] PTR_LAST = OQ_AW'(OQ_DEPTH - 1);
  localparam logic [OQ_AW:0]   CNT_FULL = (OQ_AW + 1)'(OQ_DEPTH);

  res_t             fifo_r [OQ_DEPTH];
  logic [OQ_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [OQ_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [OQ_AW:0]   cnt_r, cnt_nxt;
  logic             push_ok;
  logic             pop_ok;

  assign full    = (cnt_r == CNT_FULL);
  assign empty   = (cnt_r == '0);
  assign dout    = fifo_r[rd_ptr_r];
  assign push_ok = push && !full;
  assign pop_ok  = pop && !empty;

  // Advance pointers and fill count
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push_ok) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + OQ_AW'(1);
    end
    if (pop_ok) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + OQ_AW'(1);
    end
    if (push_ok && !pop_ok) begin
      cnt_nxt = cnt_r + (OQ_AW + 1)'(1);
    end else if (pop_ok && !push_ok) begin
      cnt_nxt = cnt_r - (OQ_AW + 1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Store the result
  always_ff @(posedge clk) begin
    if (push_ok) begin
      fifo_r[wr_ptr_r] <= din;
    end
  end

endmodule

[src/i2c_master_transaction_sequencer_core.sv]
`timescale 1ns / 1ps
// Runs one I2C master write-then-read transaction as a stream of bus commands.
// Each side is a queue: an item is taken when in_push is high and in_full low; the
// oldest result sits on the out_ ports while out_empty is low and leaves with out_pop.
// Items pass a 4-entry input queue to a step sequencer that makes one result per cycle
// into a 4-entry result queue, stalling while that queue is full. An event item runs
// one step per handled event flag and then a final stop check, other items a single
// step; each item closes with a flush step that marks its last result, and an item
// that finds the sequencer idle is first picked up. The write store is a MAX_BYTES x 8
// memory with a registered read port; it is not cleared at reset, and only bytes
// loaded since the write pointer was last cleared are read.
// Depends on i2cseq_pkg, i2cseq_front, i2cseq_back and i2cseq_outq.
module i2c_master_transaction_sequencer_core import i2cseq_pkg::*; #(
  parameter int MAX_BYTES = MAX_BYTES_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_push,
  output logic              in_full,
  input  logic [KIND_W-1:0] in_kind,
  input  logic [BYTE_W-1:0] in_device_address,
  input  logic [CNT_W-1:0]  in_write_count,
  input  logic [CNT_W-1:0]  in_read_count,
  input  logic [BYTE_W-1:0] in_tx_byte,
  input  logic              in_flag_start_sent,
  input  logic              in_flag_address_done,
  input  logic              in_flag_rx_ready,
  input  logic              in_flag_tx_empty,
  input  logic [BYTE_W-1:0] in_rx_byte,
  output logic              out_empty,
  input  logic              out_pop,
  output logic [CMD_W-1:0]  out_command,
  output logic [BYTE_W-1:0] out_data_byte,
  output logic              out_status,
  output logic              out_last
);

  item_t q_item;
  logic  q_valid;
  logic  q_take;
  res_t  oq_data;
  logic  oq_push;
  logic  oq_full;
  res_t  head;

  // Accept and classify
  i2cseq_front #(
    .MAX_BYTES (MAX_BYTES)
  ) u_front (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_push              (in_push),
    .in_full              (in_full),
    .in_kind              (in_kind),
    .in_device_address    (in_device_address),
    .in_write_count       (in_write_count),
    .in_read_count        (in_read_count),
    .in_tx_byte           (in_tx_byte),
    .in_flag_start_sent   (in_flag_start_sent),
    .in_flag_address_done (in_flag_address_done),
    .in_flag_rx_ready     (in_flag_rx_ready),
    .in_flag_tx_empty     (in_flag_tx_empty),
    .in_rx_byte           (in_rx_byte),
    .q_item               (q_item),
    .q_valid              (q_valid),
    .q_take               (q_take)
  );

  // Sequence the transaction
  i2cseq_back #(
    .MAX_BYTES (MAX_BYTES)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_item  (q_item),
    .q_valid (q_valid),
    .q_take  (q_take),
    .oq_data (oq_data),
    .oq_push (oq_push),
    .oq_full (oq_full)
  );

  // Buffer results for transfer
  i2cseq_outq u_outq (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (oq_push),
    .din   (oq_data),
    .full  (oq_full),
    .empty (out_empty),
    .pop   (out_pop),
    .dout  (head)
  );

  assign out_command   = head.command;
  assign out_data_byte = head.data_byte;
  assign out_status    = head.status;
  assign out_last      = head.last;

endmodule
